// ----- src/bimm_pkg.sv -----
// ----------------------------------------------------------------------------
// bimm_pkg
// Shared widths, codes and controller/datapath interface types for the
// banded integer matrix multiplier.
// ----------------------------------------------------------------------------
package bimm_pkg;

  localparam int MAX_DIM_DEF = 32;   // default largest matrix dimension
  localparam int RESULT_CAP  = 32;   // most results one row request may return

  localparam int IDX_W     = 5;      // row and column index fields
  localparam int VAL_W     = 32;     // element and product values
  localparam int CFG_W     = 6;      // widest configuration register
  localparam int CFG_IDX_W = 3;
  localparam int FUNC_W    = 2;
  localparam int IN_DATA_W  = 48;    // row, col, value (42 bits) padded to bytes
  localparam int OUT_DATA_W = 48;

  // Function codes carried on the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROW        = 2'd2;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_INDEX  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_left;     // store the accepted element in the left matrix
    logic wr_right;    // store the accepted element in the right matrix
    logic latch_row;   // capture the requested row and start the band division
    logic div_step;    // one restoring division step
    logic band_calc;   // register the in-band decision
    logic emit_oob;    // load the out-of-band result
    logic issue;       // read one left/right pair for the current column
    logic first;       // first inner step of a column
    logic last;        // final inner step of a column
    logic last_col;    // current column is the final one of the row
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_band;     // requested row lies in this worker's band
    logic col_done;    // a column's dot product is being loaded into the output register
    logic out_busy;    // output register holds a result not yet taken
  } status_t;

endpackage

// ----- src/banded_integer_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// banded_integer_matrix_multiply
// Loads two signed 32-bit matrices element by element and returns the
// product rows that fall in this worker's row band.
// ----------------------------------------------------------------------------
// Loads are accepted back to back while no row request is in progress.
// A row request first finds its band by a restoring division with an RW-bit
// quotient (RW = bits of MAX_DIM + 1, 6 by default), then walks the columns;
// one shared multiplier steps through one column's inner products at a time,
// reading one left and one right element a cycle from the two stores once
// the output register is free. An out-of-band request gives a single result.
// Reset clears control state and restores the register defaults; the stores
// are not cleared and read as unknown until written.
module banded_integer_matrix_multiply
  import bimm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream. tdata: row_index[4:0], col_index[9:5], elem_value[41:10],
  // zero padding up to bit 47. tuser: func[1:0].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  // Result stream. tdata: out_row[4:0], out_col[9:5], product_value[41:10],
  // zeros up to bit 47. tuser: in_band. tlast: last_of_row.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int RW  = $clog2(MAX_DIM + 1);
  localparam int KW  = $clog2(MAX_DIM);
  localparam int CLW = (RW > CFG_W) ? RW : CFG_W;
  localparam int COL_LIM = (MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP;

  // Configuration registers; writes are always taken.
  logic [CFG_W-1:0] rows_q, cols_q, inner_q, parts_q;
  logic [IDX_W-1:0] pidx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_W'(32);
      cols_q  <= CFG_W'(32);
      inner_q <= CFG_W'(32);
      parts_q <= CFG_W'(1);
      pidx_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RESULT_ROWS: rows_q  <= cfg_data_i;
        CFG_RESULT_COLS: cols_q  <= cfg_data_i;
        CFG_INNER_SIZE:  inner_q <= cfg_data_i;
        CFG_PART_COUNT:  parts_q <= cfg_data_i;
        CFG_PART_INDEX:  pidx_q  <= IDX_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sizes clamped to one up to the supported limit; zero counts as one.
  logic [RW-1:0] rows_c, cols_c, inner_c;

  assign rows_c  = (rows_q == '0) ? RW'(1) :
                   (CLW'(rows_q) > CLW'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(rows_q);
  assign cols_c  = (cols_q == '0) ? RW'(1) :
                   (CLW'(cols_q) > CLW'(COL_LIM)) ? RW'(COL_LIM) : RW'(cols_q);
  assign inner_c = (inner_q == '0) ? RW'(1) :
                   (CLW'(inner_q) > CLW'(MAX_DIM)) ? RW'(MAX_DIM) : RW'(inner_q);

  cmd_t          cmd;
  status_t       status;
  logic [KW-1:0] k, j;
  logic [IDX_W-1:0] res_row, res_col;
  logic [VAL_W-1:0] res_val;

  bimm_ctrl #(.MAX_DIM(MAX_DIM), .RW(RW), .KW(KW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .func_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .inner_i    (inner_c),
    .cols_i     (cols_c),
    .status_i   (status),
    .cmd_o      (cmd),
    .k_o        (k),
    .j_o        (j)
  );

  bimm_dpath #(.MAX_DIM(MAX_DIM), .RW(RW), .KW(KW)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .k_i          (k),
    .j_i          (j),
    .in_row_i     (s_axis_tdata[4:0]),
    .in_col_i     (s_axis_tdata[9:5]),
    .in_val_i     (s_axis_tdata[41:10]),
    .rows_i       (rows_c),
    .parts_i      (parts_q),
    .part_index_i (pidx_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (res_row),
    .out_col_o    (res_col),
    .out_val_o    (res_val),
    .out_band_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, res_val, res_col, res_row};

endmodule

// ----- src/bimm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bimm_ctrl
// Sequencer: takes input transfers, runs the band division and walks the
// columns and inner steps of a product row.
// ----------------------------------------------------------------------------
module bimm_ctrl
  import bimm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int RW      = $clog2(MAX_DIM + 1),
  parameter int KW      = $clog2(MAX_DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] func_i,
  output logic              in_ready_o,
  input  logic [RW-1:0]     inner_i,
  input  logic [RW-1:0]     cols_i,
  input  status_t           status_i,
  output cmd_t              cmd_o,
  output logic [KW-1:0]     k_o,
  output logic [KW-1:0]     j_o
);

  localparam int DCW = $clog2(RW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_BAND, ST_CHECK, ST_WAIT, ST_ISSUE, ST_DRAIN
  } state_e;

  state_e         state_q;
  logic [DCW-1:0] div_cnt_q;
  logic [KW-1:0]  k_q, j_q;
  logic           accept;
  logic           k_last, j_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign k_last     = (RW'(k_q) == inner_i - RW'(1));
  assign j_last     = (RW'(j_q) == cols_i - RW'(1));

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_left   = accept & (func_i == FUNC_LOAD_LEFT);
    cmd_o.wr_right  = accept & (func_i == FUNC_LOAD_RIGHT);
    cmd_o.latch_row = accept & (func_i == FUNC_ROW);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.band_calc = (state_q == ST_BAND);
    cmd_o.emit_oob  = (state_q == ST_CHECK) & ~status_i.in_band & ~status_i.out_busy;
    cmd_o.issue     = (state_q == ST_ISSUE);
    cmd_o.first     = (k_q == '0);
    cmd_o.last      = k_last;
    cmd_o.last_col  = j_last;
  end

  assign k_o = k_q;
  assign j_o = j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      k_q       <= '0;
      j_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && func_i == FUNC_ROW) begin
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(RW - 1)) state_q <= ST_BAND;
        end
        ST_BAND: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (!status_i.in_band) begin
            if (!status_i.out_busy) state_q <= ST_IDLE;
          end else begin
            j_q     <= '0;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!status_i.out_busy) begin
            k_q     <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k_q <= k_q + KW'(1);
          if (k_last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (status_i.col_done) begin
            if (j_last) begin
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + KW'(1);
              state_q <= ST_WAIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/bimm_dpath.sv -----
// ----------------------------------------------------------------------------
// bimm_dpath
// Matrix stores, band division, multiply-accumulate pipeline and the output
// register.
// ----------------------------------------------------------------------------
module bimm_dpath
  import bimm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int RW      = $clog2(MAX_DIM + 1),
  parameter int KW      = $clog2(MAX_DIM)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [KW-1:0]      k_i,
  input  logic [KW-1:0]      j_i,
  input  logic [IDX_W-1:0]   in_row_i,
  input  logic [IDX_W-1:0]   in_col_i,
  input  logic [VAL_W-1:0]   in_val_i,
  input  logic [RW-1:0]      rows_i,
  input  logic [CFG_W-1:0]   parts_i,
  input  logic [IDX_W-1:0]   part_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   out_row_o,
  output logic [IDX_W-1:0]   out_col_o,
  output logic [VAL_W-1:0]   out_val_o,
  output logic               out_band_o,
  output logic               out_last_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = RW + CFG_W + 1;

  logic [VAL_W-1:0] left_mem  [DEPTH];
  logic [VAL_W-1:0] right_mem [DEPTH];

  logic [IDX_W-1:0] row_q;
  logic             ld_ok;
  logic [AW-1:0]    wr_addr, left_rd_addr, right_rd_addr;

  assign ld_ok   = (32'(in_row_i) < MAX_DIM) && (32'(in_col_i) < MAX_DIM);
  assign wr_addr = AW'(AW'(in_row_i) * AW'(MAX_DIM)) + AW'(in_col_i);
  assign left_rd_addr  = AW'(AW'(row_q) * AW'(MAX_DIM)) + AW'(k_i);
  assign right_rd_addr = AW'(AW'(k_i) * AW'(MAX_DIM)) + AW'(j_i);

  // Pipeline: read -> multiply -> accumulate.
  logic [VAL_W-1:0] lv_q, rv_q, prod_q, acc_q, acc_d;
  logic             p1_valid_q, p1_first_q, p1_last_q, p1_lcol_q;
  logic             p2_valid_q, p2_first_q, p2_last_q, p2_lcol_q;
  logic [KW-1:0]    p1_j_q, p2_j_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_left && ld_ok) left_mem[wr_addr] <= in_val_i;
    if (cmd_i.wr_right && ld_ok) right_mem[wr_addr] <= in_val_i;
    lv_q <= left_mem[left_rd_addr];
    rv_q <= right_mem[right_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.issue;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= cmd_i.first;
    p1_last_q  <= cmd_i.last;
    p1_lcol_q  <= cmd_i.last_col;
    p1_j_q     <= j_i;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    p2_lcol_q  <= p1_lcol_q;
    p2_j_q     <= p1_j_q;
    prod_q     <= VAL_W'(lv_q * rv_q);
    if (p2_valid_q) acc_q <= acc_d;
  end

  assign acc_d = p2_first_q ? prod_q : acc_q + prod_q;

  // Band division: rows / parts by restoring steps, one quotient bit a cycle.
  logic [RW-1:0]    quo_q;
  logic [CFG_W-1:0] rem_q;
  logic [CFG_W-1:0] parts;
  logic [CFG_W:0]   rem_sh;
  logic             take;
  logic [SW-1:0]    start, stop, pi_w, extra_w, per_w;
  logic             pi_lt_extra, inside_q;

  assign parts  = (parts_i == '0) ? CFG_W'(1) : parts_i;
  assign rem_sh = {rem_q, quo_q[RW-1]};
  assign take   = (rem_sh >= {1'b0, parts});

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_row) begin
      row_q <= in_row_i;
      quo_q <= rows_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? CFG_W'(rem_sh - {1'b0, parts}) : CFG_W'(rem_sh);
      quo_q <= {quo_q[RW-2:0], take};
    end
  end

  assign pi_w        = SW'(part_index_i);
  assign extra_w     = SW'(rem_q);
  assign per_w       = SW'(quo_q);
  assign pi_lt_extra = (pi_w < extra_w);
  assign start       = SW'(pi_w * per_w) + (pi_lt_extra ? pi_w : extra_w);
  assign stop        = start + per_w + SW'(pi_lt_extra);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.band_calc) begin
      inside_q <= (pi_w < SW'(parts)) && (SW'(row_q) >= start) && (SW'(row_q) < stop)
                  && (SW'(row_q) < SW'(rows_i));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_oob || (p2_valid_q && p2_last_q)) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_oob) begin
      out_row_o  <= row_q;
      out_col_o  <= '0;
      out_val_o  <= '0;
      out_band_o <= 1'b0;
      out_last_o <= 1'b1;
    end else if (p2_valid_q && p2_last_q) begin
      out_row_o  <= row_q;
      out_col_o  <= IDX_W'(p2_j_q);
      out_val_o  <= acc_d;
      out_band_o <= 1'b1;
      out_last_o <= p2_lcol_q;
    end
  end

  assign status_o.in_band  = inside_q;
  assign status_o.col_done = p2_valid_q & p2_last_q;
  assign status_o.out_busy = out_valid_o;

endmodule

// ----- src/bimm_checker.sv -----
// ----------------------------------------------------------------------------
// bimm_checker
// Port-level checks for the banded integer matrix multiplier.
// ----------------------------------------------------------------------------
module bimm_checker
  import bimm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [FUNC_W-1:0]     s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before transfer");

  // An out-of-band result is always the final one of its request.
  a_oob_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("out-of-band result not marked last");

  // An out-of-band result carries column zero and value zero.
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:5] == '0)
    else $error("out-of-band result carries data");

  // A row request closes the input for at least the next cycle.
  a_row_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_ROW |=> !s_axis_tready)
    else $error("input open straight after a row request");

endmodule

bind banded_integer_matrix_multiply bimm_checker u_bimm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/banded_integer_matrix_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// Banded integer matrix multiply testbench
// Loads both matrices, configures sizes and row bands, requests product rows
// and checks every result against a behavioural model of the band split and
// the wrapped dot products, with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module banded_integer_matrix_multiply_tb;
  import bimm_pkg::*;

  localparam int DIM = 32;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             in_band;
    logic             last;
  } product_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = FUNC_LOAD_LEFT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_RESULT_ROWS;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  // Model state: the two stores and the register copies.
  logic [VAL_W-1:0] left_mem [DIM*DIM];
  logic [VAL_W-1:0] right_mem [DIM*DIM];
  logic [5:0] rows_reg, cols_reg, inner_reg, parts_reg;
  logic [4:0] part_reg;

  product_t pending_products[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  banded_integer_matrix_multiply u_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int clamp_size(logic [5:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  // Works out the results of one accepted item and queues them.
  task automatic predict_products(logic [FUNC_W-1:0] func, logic [4:0] row,
                                  logic [4:0] col, logic [VAL_W-1:0] value);
    int rows, cols, inner, parts, per, extra, start, stop;
    bit hit;
    logic [VAL_W-1:0] sum;
    product_t p;
    if (func == FUNC_LOAD_LEFT) left_mem[row*DIM+col] = value;
    else if (func == FUNC_LOAD_RIGHT) right_mem[row*DIM+col] = value;
    if (func != FUNC_ROW) return;
    rows = clamp_size(rows_reg);
    cols = clamp_size(cols_reg);
    inner = clamp_size(inner_reg);
    parts = (parts_reg == 0) ? 1 : parts_reg;
    per = rows / parts;
    extra = rows % parts;
    hit = 1'b0;
    if (part_reg < parts) begin
      start = part_reg * per + ((part_reg < extra) ? part_reg : extra);
      stop = start + per + ((part_reg < extra) ? 1 : 0);
      hit = (row >= start) && (row < stop) && (row < rows);
    end
    if (!hit) begin
      p = '{row, '0, '0, 1'b0, 1'b1};
      pending_products.push_back(p);
      return;
    end
    for (int j = 0; j < cols; j++) begin
      sum = '0;
      for (int k = 0; k < inner; k++)
        sum = sum + left_mem[row*DIM+k] * right_mem[k*DIM+j];
      p = '{row, j[4:0], sum, 1'b1, j == cols - 1};
      pending_products.push_back(p);
    end
  endtask

  // Sends one item; the sender drops valid for random gaps between bursts.
  int burst_left = 0;
  task automatic send_item(logic [FUNC_W-1:0] func, int row, int col,
                           logic [VAL_W-1:0] value);
    int gap;
    logic [IDX_W-1:0] row_w, col_w;
    row_w = IDX_W'(row);
    col_w = IDX_W'(col);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {6'd0, value, col_w, row_w};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_products(func, row_w, col_w, value);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_products.size() != 0) @(negedge clk_i);
    // A trailing load may still be in flight.
    repeat (20) @(negedge clk_i);
  endtask

  // Holds the write channel valid; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RESULT_ROWS: rows_reg = CFG_W'(value);
      CFG_RESULT_COLS: cols_reg = CFG_W'(value);
      CFG_INNER_SIZE:  inner_reg = CFG_W'(value);
      CFG_PART_COUNT:  parts_reg = CFG_W'(value);
      CFG_PART_INDEX:  part_reg = IDX_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_shape(int r, int c, int k, int n, int idx);
    go_idle();
    write_reg(CFG_RESULT_ROWS, r);
    write_reg(CFG_RESULT_COLS, c);
    write_reg(CFG_INNER_SIZE, k);
    write_reg(CFG_PART_COUNT, n);
    write_reg(CFG_PART_INDEX, idx);
    cfg_valid_i <= 1'b0;
  endtask

  // Fills every entry that a later request reads, so none reads an unwritten one.
  task automatic test_fill_stores();
    logic [VAL_W-1:0] v;
    for (int i = 0; i < 13; i++)
      for (int j = 0; j < 8; j++) begin
        v = $urandom;
        send_item(FUNC_LOAD_LEFT, i, j, v);
      end
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 6; j++) begin
        v = $urandom;
        send_item(FUNC_LOAD_RIGHT, i, j, v);
      end
    for (int j = 0; j < DIM; j++) begin
      v = $urandom;
      send_item(FUNC_LOAD_LEFT, 31, j, v);
    end
    for (int i = 8; i < DIM; i++) begin
      v = $urandom;
      send_item(FUNC_LOAD_RIGHT, i, 0, v);
    end
  endtask

  // Extreme values, unused function code and rows inside and after the band.
  task automatic test_directed();
    send_item(FUNC_LOAD_LEFT, 0, 0, 32'h8000_0000);
    send_item(FUNC_LOAD_RIGHT, 0, 0, 32'h7FFF_FFFF);
    send_item(FUNC_LOAD_LEFT, 31, 31, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD_RIGHT, 31, 31, 32'hFFFF_FFFF);
    send_item(FUNC_UNUSED, 31, 31, 32'hFFFF_FFFF);
    set_shape(1, 1, 1, 1, 0);
    send_item(FUNC_ROW, 0, 31, '0);
    send_item(FUNC_ROW, 1, 0, '0);
    set_shape(7, 3, 2, 3, 0);
    for (int r = 0; r < 8; r++) send_item(FUNC_ROW, r, 0, '0);
    set_shape(7, 3, 2, 3, 2);
    send_item(FUNC_ROW, 5, 0, '0);
    send_item(FUNC_ROW, 6, 0, '0);
    set_shape(0, 0, 0, 0, 0);
    send_item(FUNC_ROW, 0, 0, '0);
    set_shape(4, 2, 32, 2, 5);
    send_item(FUNC_ROW, 0, 0, '0);
    // Oversized rows and inner size clamp to the full dimension.
    set_shape(63, 1, 63, 1, 0);
    send_item(FUNC_ROW, 31, 0, '0);
  endtask

  // Random small shapes and band indices; row requests over rows 0 to 12, mixed with loads.
  task automatic test_random();
    int n, r;
    for (int phase = 0; phase < 8; phase++) begin
      n = $urandom_range(1, 6);
      set_shape($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 8), n,
                $urandom_range(0, n));
      for (int i = 0; i < 30; i++) begin
        r = $urandom_range(0, 3);
        if (r == 0)
          send_item(($urandom_range(0, 1) == 0) ? FUNC_LOAD_LEFT : FUNC_LOAD_RIGHT,
                    $urandom, $urandom, $urandom);
        else if (r == 3 && i % 9 == 0) send_item(FUNC_UNUSED, $urandom, $urandom, $urandom);
        else send_item(FUNC_ROW, $urandom_range(0, 12), $urandom, $urandom);
      end
    end
  endtask

  // The receiver stops for a long stretch while row requests keep arriving.
  task automatic test_backpressure();
    set_shape(8, 4, 2, 1, 0);
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 10; i++) send_item(FUNC_ROW, i % 8, 0, '0);
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver stall pattern: runs of steady ready between stretches of random ready.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (cycles % 200 < 60) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    product_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tdata[41:10],
              m_axis_tuser, m_axis_tlast};
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_products.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    rows_reg = 6'd32; cols_reg = 6'd32; inner_reg = 6'd32; parts_reg = 6'd1; part_reg = 5'd0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_fill_stores();
    test_directed();
    test_backpressure();
    test_random();
    go_idle();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending_products.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- banded_integer_matrix_multiply.f -----
src/bimm_pkg.sv
src/bimm_ctrl.sv
src/bimm_dpath.sv
src/banded_integer_matrix_multiply.sv
src/bimm_checker.sv
bench/banded_integer_matrix_multiply_tb.sv
